@@ sv/assert_macros.svh @@
// assertion macros shared by the lock controller rtl
// no dependencies; expects signals named clock and reset in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define KPLC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked on every edge including reset
`define KPLC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

@@ sv/kplc_pkg.sv @@
// shared types and constants of the keypad password lock controller
// no dependencies
package kplc_pkg;

   localparam int MAX_KEYS_DEFAULT = 10;

   localparam int PUK_W    = 40;
   localparam int TICK_W   = 8;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 64;

   localparam logic [PUK_W-1:0]  PUK_RESET     = 40'h01_2345_6789;
   localparam logic [TICK_W-1:0] LOCKOUT_RESET = 8'd59;

   // configuration handed from the register block to the controller
   typedef struct packed {
      logic [PUK_W-1:0]  puk_digits;
      logic [TICK_W-1:0] lockout_ticks;
   } cfg_type;

endpackage

@@ sv/kplc_csr.sv @@
// configuration registers of the lock controller on an apb-style port
// depends on kplc_pkg
module kplc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [kplc_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [kplc_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [kplc_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready,
   output kplc_pkg::cfg_type             cfg
);

   // registers sit 8 bytes apart, so bit 3 of the address picks one
   typedef enum logic {
      REG_PUK     = 1'b0,
      REG_LOCKOUT = 1'b1
   } reg_sel_type;

   kplc_pkg::cfg_type cfg_ff;
   logic              wr_en;
   reg_sel_type       sel;

   assign sel        = reg_sel_type'(csr_paddr[3]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.puk_digits    <= kplc_pkg::PUK_RESET;
         cfg_ff.lockout_ticks <= kplc_pkg::LOCKOUT_RESET;
      end else if (wr_en) begin
         case (sel)
            REG_PUK: begin
               cfg_ff.puk_digits <= csr_pwdata[kplc_pkg::PUK_W-1:0];
            end
            REG_LOCKOUT: begin
               cfg_ff.lockout_ticks <= csr_pwdata[kplc_pkg::TICK_W-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (sel)
         REG_PUK: begin
            csr_prdata[kplc_pkg::PUK_W-1:0] = cfg_ff.puk_digits;
         end
         REG_LOCKOUT: begin
            csr_prdata[kplc_pkg::TICK_W-1:0] = cfg_ff.lockout_ticks;
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

endmodule

@@ sv/keypad_password_lock_controller_top.sv @@
// keypad password lock controller: mode sequencer, entry editor and result register
// depends on kplc_pkg, kplc_csr and assert_macros.svh
//
//   channel   direction   handshake                         payload
//   req_      in          req_valid / req_stall             command, key_code
//   rsp_      out         rsp_valid / rsp_stall             mode .. countdown
//   csr_      in/out      psel, penable, pwrite, pready=1   puk_digits, lockout_ticks
//
// one transfer in, one transfer out; the result is registered on acceptance
// a new item is taken every cycle; the single result register limits it when rsp_stall holds
// req_stall is high only while a result waits and rsp_stall is high
// synchronous reset restores mode, counters, saved password and configuration
`include "assert_macros.svh"

module keypad_password_lock_controller_top #(
   parameter int MAX_KEYS = kplc_pkg::MAX_KEYS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_command,
   input  logic [7:0]                    req_key_code,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_mode,
   output logic [3:0]                    rsp_entry_length,
   output logic [3:0]                    rsp_event_res,
   output logic                          rsp_motor_enable,
   output logic                          rsp_motor_open_dir,
   output logic                          rsp_buzzer_on,
   output logic [3:0]                    rsp_trial_count,
   output logic [7:0]                    rsp_countdown,
   // configuration port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [kplc_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [kplc_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [kplc_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);

   // counter wide enough to hold MAX_KEYS itself, index just wide enough for the entries
   localparam int CW      = $clog2(MAX_KEYS + 1);
   localparam int IW      = $clog2(MAX_KEYS);
   localparam int PUK_LEN = 10;

   localparam logic [7:0] KEY_END   = 8'd35;   // '#'
   localparam logic [7:0] KEY_ERASE = 8'd42;   // '*'
   localparam logic [7:0] KEY_ZERO  = 8'd48;   // '0'
   localparam logic [7:0] KEY_ONE   = 8'd49;
   localparam logic [7:0] KEY_TWO   = 8'd50;
   localparam logic [7:0] KEY_THREE = 8'd51;
   localparam logic [7:0] KEY_FOUR  = 8'd52;

   typedef enum logic [2:0] {
      MODE_WELCOME = 3'd0,
      MODE_MENU    = 3'd1,
      MODE_LOGIN   = 3'd2,
      MODE_OLD     = 3'd3,
      MODE_NEW1    = 3'd4,
      MODE_NEW2    = 3'd5,
      MODE_LOCKOUT = 3'd6,
      MODE_PUK     = 3'd7
   } mode_type;

   typedef enum logic [3:0] {
      EV_NONE      = 4'd0,
      EV_STORED    = 4'd1,
      EV_ERASED    = 4'd2,
      EV_IGNORED   = 4'd3,
      EV_OPENED    = 4'd4,
      EV_CLOSED    = 4'd5,
      EV_WRONG     = 4'd6,
      EV_LOCKOUT   = 4'd7,
      EV_LOCK_OVER = 4'd8,
      EV_PERM_LOCK = 4'd9,
      EV_SAVED     = 4'd10,
      EV_MISMATCH  = 4'd11,
      EV_PUK_WRONG = 4'd12,
      EV_PUK_OK    = 4'd13
   } event_type;

   typedef enum logic [1:0] {
      CMD_KEY   = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_CLOSE = 2'd2
   } cmd_type;

   // configuration registers
   kplc_pkg::cfg_type cfg;

   kplc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // controller state
   mode_type      mode_ff, mode_in;
   logic [CW-1:0] entry_count_ff, entry_count_in;
   logic [CW-1:0] first_len_ff, first_len_in;
   logic [CW-1:0] saved_len_ff, saved_len_in;
   logic [3:0]    trials_ff, trials_in;
   logic [7:0]    left_ff, left_in;
   logic [7:0]    entry_buf_ff [MAX_KEYS];
   logic [7:0]    first_buf_ff [MAX_KEYS];
   logic [7:0]    saved_buf_ff [MAX_KEYS];

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   mode_type      rsp_mode_ff;
   logic [3:0]    rsp_len_ff;
   event_type     rsp_event_ff;
   logic [3:0]    rsp_trials_ff;
   logic [7:0]    rsp_left_ff;

   logic          accept;
   cmd_type       cmd;
   event_type     ev;
   logic          wr_entry;      // store the key at the current entry position
   logic          copy_first;    // first new password taken from the entry buffer
   logic          copy_saved;    // saved password taken from the first new password
   logic          login_match;
   logic          new_match;
   logic          puk_match;
   logic [3:0]    trials_inc;
   logic [7:0]    left_dec;
   logic [CW+3:0] count_ext;
   logic          rsp_opened;    // an open result is on the output
   logic          open_clean;    // welcome with trials cleared on the output

   // a result waiting on a stalled output is the only thing that holds the input
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign cmd       = cmd_type'(req_command);

   // entry against saved password, and first against second new password
   always_comb begin
      login_match = (entry_count_ff == saved_len_ff);
      new_match   = (entry_count_ff == first_len_ff);
      for (int i = 0; i < MAX_KEYS; i++) begin
         if (CW'(i) < entry_count_ff) begin
            login_match = login_match && (entry_buf_ff[i] == saved_buf_ff[i]);
            new_match   = new_match && (entry_buf_ff[i] == first_buf_ff[i]);
         end
      end
   end

   // puk digits against the ten held keys, each taken as key minus ascii zero
   generate
      if (MAX_KEYS >= PUK_LEN) begin : g_puk
         always_comb begin
            logic [7:0] digit_val;
            puk_match = (entry_count_ff == CW'(PUK_LEN));
            for (int i = 0; i < PUK_LEN; i++) begin
               digit_val = entry_buf_ff[i] - KEY_ZERO;
               puk_match = puk_match &&
                  (digit_val == {4'b0000, cfg.puk_digits[kplc_pkg::PUK_W-1-4*i -: 4]});
            end
         end
      end else begin : g_no_puk
         // too few keys for a full unlock code
         assign puk_match = 1'b0;
      end
   endgenerate

   assign trials_inc = (trials_ff == 4'hf) ? trials_ff : trials_ff + 4'd1;
   assign left_dec   = (left_ff != 8'd0) ? left_ff - 8'd1 : left_ff;

   // next state and result of the accepted item
   always_comb begin
      mode_in        = mode_ff;
      entry_count_in = entry_count_ff;
      first_len_in   = first_len_ff;
      saved_len_in   = saved_len_ff;
      trials_in      = trials_ff;
      left_in        = left_ff;
      ev             = EV_NONE;
      wr_entry       = 1'b0;
      copy_first     = 1'b0;
      copy_saved     = 1'b0;

      case (cmd)
         CMD_KEY: begin
            if (mode_ff == MODE_WELCOME) begin
               mode_in = MODE_MENU;
            end else if (mode_ff == MODE_MENU) begin
               if (req_key_code == KEY_ONE) begin
                  mode_in        = MODE_LOGIN;
                  entry_count_in = '0;
               end else if (req_key_code == KEY_TWO) begin
                  mode_in        = MODE_OLD;
                  entry_count_in = '0;
               end else begin
                  ev = EV_IGNORED;
               end
            end else if (mode_ff == MODE_LOCKOUT) begin
               ev = EV_IGNORED;
            end else if (req_key_code == KEY_END) begin
               // entry finished: act on the mode, then empty the buffer
               entry_count_in = '0;
               case (mode_ff)
                  MODE_LOGIN: begin
                     if (login_match) begin
                        trials_in = 4'd0;
                        mode_in   = MODE_WELCOME;
                        ev        = EV_OPENED;
                     end else begin
                        trials_in = trials_inc;
                        if (trials_inc == 4'd3 || trials_inc == 4'd6) begin
                           left_in = cfg.lockout_ticks;
                           mode_in = MODE_LOCKOUT;
                           ev      = EV_LOCKOUT;
                        end else if (trials_inc >= 4'd9) begin
                           mode_in = MODE_PUK;
                           ev      = EV_PERM_LOCK;
                        end else begin
                           ev = EV_WRONG;
                        end
                     end
                  end
                  MODE_OLD: begin
                     if (login_match) begin
                        mode_in = MODE_NEW1;
                     end else begin
                        ev = EV_WRONG;
                     end
                  end
                  MODE_NEW1: begin
                     copy_first   = 1'b1;
                     first_len_in = entry_count_ff;
                     mode_in      = MODE_NEW2;
                  end
                  MODE_NEW2: begin
                     if (new_match) begin
                        copy_saved   = 1'b1;
                        saved_len_in = first_len_ff;
                        mode_in      = MODE_WELCOME;
                        ev           = EV_SAVED;
                     end else begin
                        mode_in = MODE_NEW1;
                        ev      = EV_MISMATCH;
                     end
                  end
                  default: begin
                     // unlock code mode
                     if (puk_match) begin
                        trials_in = 4'd0;
                        mode_in   = MODE_NEW1;
                        ev        = EV_PUK_OK;
                     end else begin
                        ev = EV_PUK_WRONG;
                     end
                  end
               endcase
            end else if (req_key_code == KEY_ERASE) begin
               if (entry_count_ff != '0) begin
                  entry_count_in = entry_count_ff - CW'(1);
                  ev             = EV_ERASED;
               end else begin
                  ev = EV_IGNORED;
               end
            end else if (entry_count_ff < CW'(MAX_KEYS)) begin
               wr_entry       = 1'b1;
               entry_count_in = entry_count_ff + CW'(1);
               ev             = EV_STORED;
            end else begin
               ev = EV_IGNORED;
            end
         end
         CMD_TICK: begin
            if (mode_ff == MODE_LOCKOUT) begin
               left_in = left_dec;
               if (left_dec == 8'd0) begin
                  mode_in        = MODE_LOGIN;
                  entry_count_in = '0;
                  ev             = EV_LOCK_OVER;
               end
            end
         end
         CMD_CLOSE: begin
            ev = EV_CLOSED;
         end
         default: begin
            ev = EV_IGNORED;
         end
      endcase

      // countdown only lives in lockout
      if (mode_in != MODE_LOCKOUT) begin
         left_in = 8'd0;
      end
   end

   assign count_ext = {4'b0000, entry_count_in};

   // result register is loaded on acceptance and emptied once taken
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_WELCOME;
         entry_count_ff  <= '0;
         first_len_ff    <= '0;
         saved_len_ff    <= CW'(4);
         trials_ff       <= 4'd0;
         left_ff         <= 8'd0;
         rsp_valid_ff    <= 1'b0;
         // factory password "1234", the rest cleared
         saved_buf_ff[0] <= KEY_ONE;
         saved_buf_ff[1] <= KEY_TWO;
         saved_buf_ff[2] <= KEY_THREE;
         saved_buf_ff[3] <= KEY_FOUR;
         for (int i = 4; i < MAX_KEYS; i++) begin
            saved_buf_ff[i] <= 8'd0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            mode_ff        <= mode_in;
            entry_count_ff <= entry_count_in;
            first_len_ff   <= first_len_in;
            saved_len_ff   <= saved_len_in;
            trials_ff      <= trials_in;
            left_ff        <= left_in;
            if (wr_entry) begin
               entry_buf_ff[entry_count_ff[IW-1:0]] <= req_key_code;
            end
            if (copy_first) begin
               first_buf_ff <= entry_buf_ff;
            end
            if (copy_saved) begin
               saved_buf_ff <= first_buf_ff;
            end
            rsp_mode_ff   <= mode_in;
            rsp_len_ff    <= count_ext[3:0];
            rsp_event_ff  <= ev;
            rsp_trials_ff <= trials_in;
            rsp_left_ff   <= left_in;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mode           = rsp_mode_ff;
   assign rsp_entry_length   = rsp_len_ff;
   assign rsp_event_res      = rsp_event_ff;
   assign rsp_motor_enable   = (rsp_event_ff == EV_OPENED) || (rsp_event_ff == EV_CLOSED);
   assign rsp_motor_open_dir = (rsp_event_ff == EV_OPENED);
   assign rsp_buzzer_on      = (rsp_event_ff == EV_CLOSED);
   assign rsp_trial_count    = rsp_trials_ff;
   assign rsp_countdown      = rsp_left_ff;

   assign rsp_opened = rsp_valid_ff && (rsp_event_ff == EV_OPENED);
   assign open_clean = (rsp_mode_ff == MODE_WELCOME) && (rsp_trials_ff == 4'd0);

   // the editor never holds more keys than the buffer has room for
   `KPLC_ASSERT(a_count_range, entry_count_ff <= CW'(MAX_KEYS), "entry count beyond buffer")
   // unlock code mode is only reached after nine wrong logins
   `KPLC_ASSERT(a_puk_trials, mode_ff != MODE_PUK || trials_ff >= 4'd9, "puk with few trials")
   // countdown is zero outside lockout
   `KPLC_ASSERT(a_left_mode, mode_ff == MODE_LOCKOUT || left_ff == 8'd0, "countdown outside lockout")
   // an open always lands in welcome with trials cleared
   `KPLC_ASSERT(a_open_clean, !rsp_opened || open_clean, "open with stale state")
   // input is held back only by a waiting result
   `KPLC_ASSERT_ALWAYS(a_stall_cause, !req_stall || rsp_valid_ff, "stall without pending result")

endmodule
